### rtl/nst_pkg.sv
// ----------------------------------------------------------------------------
// nst_pkg
// Shared types and constants for the notification slot table.
// ----------------------------------------------------------------------------
package nst_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int SLOT_W     = 8;
    localparam int LINK_W     = 16;
    localparam int GEN_W      = 32;
    localparam int SEQ_W      = 32;
    localparam int TAG_W      = 16;
    localparam int MASK_W     = 64;
    localparam int MASK_IDX_W = 6;
    localparam int CNT_W      = 32;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [1:0] ACT_ATTACH  = 2'd0;
    localparam logic [1:0] ACT_DETACH  = 2'd1;
    localparam logic [1:0] ACT_PUBLISH = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    // register index = paddr[2]
    localparam logic REG_ADMISSION = 1'b0;

    localparam logic [GEN_W-1:0] GEN_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [1:0]        action;
        logic [SLOT_W-1:0] slot;
        logic [LINK_W-1:0] link_id;
        logic [GEN_W-1:0]  generation;
        logic [SEQ_W-1:0]  sequence_req;
        logic [TAG_W-1:0]  tag;
    } req_t;

    typedef struct packed {
        logic              bound;
        logic [LINK_W-1:0] owner;
        logic [GEN_W-1:0]  generation;
        logic [SEQ_W-1:0]  last_sequence;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic              accepted;
        logic [GEN_W-1:0]  new_generation;
        logic [MASK_W-1:0] pending_mask;
        logic [CNT_W-1:0]  pending_count;
        logic              activate;
        logic [SEQ_W-1:0]  mirror_sequence;
        logic [TAG_W-1:0]  mirror_tag;
        logic              mirror_write;
    } res_t;

    typedef struct packed {
        logic   en;
        entry_t data;
    } wr_t;

endpackage

### rtl/nst_slot_mem.sv
// ----------------------------------------------------------------------------
// nst_slot_mem
// Slot entry memory, one write and one registered read port; per-entry
// valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module nst_slot_mem #(
    parameter int SLOTS = nst_pkg::SLOTS_DEF,
    parameter int IDX_W = 6
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output nst_pkg::entry_t rd_entry,
    input  nst_pkg::wr_t   wr,
    input  logic [IDX_W-1:0] wr_addr
);
    import nst_pkg::*;

    entry_t           mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    entry_t           rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/nst_eval.sv
// ----------------------------------------------------------------------------
// nst_eval
// Checks one request against its slot entry and forms the result, the
// entry write-back and the new mask and counter.
// ----------------------------------------------------------------------------
module nst_eval #(
    parameter int SLOTS = nst_pkg::SLOTS_DEF
) (
    input  nst_pkg::req_t                    req,
    input  nst_pkg::entry_t                  entry,
    input  logic                             admission_closed,
    input  logic [nst_pkg::MASK_W-1:0]       mask_in,
    input  logic [nst_pkg::CNT_W-1:0]        count_in,
    output nst_pkg::res_t                    res,
    output nst_pkg::wr_t                     wr
);
    import nst_pkg::*;

    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W+1)'(SLOTS);

    logic                  in_range;
    logic                  owns;
    logic [MASK_IDX_W-1:0] bit_idx;

    assign in_range = {1'b0, req.slot} < SLOT_LIMIT;
    assign owns     = entry.bound && (entry.owner == req.link_id) &&
                      (entry.generation == req.generation);
    assign bit_idx  = req.slot[MASK_IDX_W-1:0];

    always_comb begin
        res               = '0;
        res.pending_mask  = mask_in;
        res.pending_count = count_in;
        wr.en             = 1'b0;
        wr.data           = entry;
        if (in_range) begin
            unique case (req.action)
                ACT_ATTACH: begin
                    if (!admission_closed && !entry.bound &&
                        entry.generation != GEN_MAX) begin
                        wr.en                 = 1'b1;
                        wr.data.generation    = entry.generation + GEN_W'(1);
                        wr.data.bound         = 1'b1;
                        wr.data.owner         = req.link_id;
                        wr.data.last_sequence = '0;
                        wr.data.tag           = req.tag;
                        res.accepted          = 1'b1;
                        res.new_generation    = entry.generation + GEN_W'(1);
                    end
                end
                ACT_DETACH: begin
                    if (owns) begin
                        wr.en                     = 1'b1;
                        wr.data.bound             = 1'b0;
                        wr.data.last_sequence     = '0;
                        wr.data.tag               = '0;
                        res.pending_mask[bit_idx] = 1'b0;
                        res.accepted              = 1'b1;
                        res.mirror_write          = 1'b1;
                    end
                end
                ACT_PUBLISH: begin
                    if (owns && entry.tag == req.tag &&
                        req.sequence_req > entry.last_sequence) begin
                        wr.en                     = 1'b1;
                        wr.data.last_sequence     = req.sequence_req;
                        if (count_in != CNT_MAX) begin
                            res.pending_count = count_in + CNT_W'(1);
                        end
                        res.pending_mask[bit_idx] = 1'b1;
                        res.accepted              = 1'b1;
                        res.activate              = 1'b1;
                        res.mirror_sequence       = req.sequence_req;
                        res.mirror_tag            = req.tag;
                        res.mirror_write          = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    if (owns && entry.last_sequence == req.sequence_req) begin
                        wr.en                     = 1'b1;
                        wr.data.last_sequence     = '0;
                        res.pending_mask[bit_idx] = 1'b0;
                        res.accepted              = 1'b1;
                        res.mirror_tag            = entry.tag;
                        res.mirror_write          = 1'b1;
                    end
                end
                default: begin
                    wr.en = 1'b0;
                end
            endcase
        end
    end

endmodule

### rtl/nst_apb_regs.sv
// ----------------------------------------------------------------------------
// nst_apb_regs
// APB register block holding the admission control bit.
// ----------------------------------------------------------------------------
module nst_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nst_pkg::APB_AW-1:0] paddr,
    input  logic [nst_pkg::APB_DW-1:0] pwdata,
    output logic [nst_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic                       admission_closed
);
    import nst_pkg::*;

    logic admission_reg;
    logic admission_next;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ADMISSION);

    always_comb begin
        admission_next = admission_reg;
        if (wr_hit) begin
            admission_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            admission_reg <= 1'b0;
        end else begin
            admission_reg <= admission_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ADMISSION: prdata = {{(APB_DW-1){1'b0}}, admission_reg};
            default:       prdata = '0;
        endcase
    end

    assign admission_closed = admission_reg;

endmodule

### rtl/notification_slot_table.sv
// ----------------------------------------------------------------------------
// notification_slot_table
// Notification slot table: attach, detach, publish and clear requests
// against a memory of slot entries, with a pending mask and counter.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         words
//  --------  ---  ----------------  -------------------------------------
//  s_*       in   s_valid/s_ready   one request word
//  m_*       out  m_valid/m_ready   one result word per request
//  APB       in   psel/penable      admission_closed at byte address 0
//
//  At acceptance the request is registered into the check stage and its slot
//  entry is read (registered read); there the entry is checked, written back
//  and loaded into the result register when the stage advances, which raises
//  m_valid. The read of the next request overlaps the write-back of the
//  current one, so a word per cycle is sustained while m_ready does not stall;
//  the read and write of one slot in the same cycle are forwarded.
//  Reset (aresetn low, synchronous) clears the entry valid bits, mask,
//  counter and admission register; no clearing pass is needed.
//  A stalled m_ready holds the request in the check stage and drops s_ready.
//
module notification_slot_table #(
    parameter int SLOTS = nst_pkg::SLOTS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic [nst_pkg::SLOT_W-1:0] s_slot,
    input  logic [nst_pkg::LINK_W-1:0] s_link_id,
    input  logic [nst_pkg::GEN_W-1:0]  s_generation,
    input  logic [nst_pkg::SEQ_W-1:0]  s_sequence_req,
    input  logic [nst_pkg::TAG_W-1:0]  s_tag,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic [nst_pkg::GEN_W-1:0]  m_new_generation,
    output logic [nst_pkg::MASK_W-1:0] m_pending_mask,
    output logic [nst_pkg::CNT_W-1:0]  m_pending_count,
    output logic                       m_activate,
    output logic [nst_pkg::SEQ_W-1:0]  m_mirror_sequence,
    output logic [nst_pkg::TAG_W-1:0]  m_mirror_tag,
    output logic                       m_mirror_write,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nst_pkg::APB_AW-1:0] paddr,
    input  logic [nst_pkg::APB_DW-1:0] pwdata,
    output logic [nst_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import nst_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W+1)'(SLOTS);

    logic   admission_closed;

    // check stage
    req_t   req_reg;
    logic   req_valid_reg;
    logic   fwd_reg;
    entry_t fwd_data_reg;

    // result register
    res_t   out_reg;
    logic   out_valid_reg;

    // accumulated state
    logic [MASK_W-1:0] mask_reg;
    logic [CNT_W-1:0]  count_reg;

    logic   s_accept;
    logic   advance;
    logic   rd_en;
    entry_t mem_entry;
    entry_t cur_entry;
    res_t   eval_res;
    wr_t    eval_wr;
    wr_t    mem_wr;
    req_t   s_req;

    assign s_req = '{action:       s_action,
                     slot:         s_slot,
                     link_id:      s_link_id,
                     generation:   s_generation,
                     sequence_req: s_sequence_req,
                     tag:          s_tag};

    // advance the check stage when the result register is free or emptying
    assign advance  = req_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !req_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    // read only in-range slots so a short table is never indexed past its end
    assign rd_en = s_accept && ({1'b0, s_slot} < SLOT_LIMIT);

    nst_apb_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .admission_closed (admission_closed)
    );

    // write back only when the check stage actually completes
    always_comb begin
        mem_wr    = eval_wr;
        mem_wr.en = eval_wr.en && advance;
    end

    nst_slot_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (s_slot[IDX_W-1:0]),
        .rd_entry (mem_entry),
        .wr       (mem_wr),
        .wr_addr  (req_reg.slot[IDX_W-1:0])
    );

    // take the forwarded entry when the read raced the previous write-back
    assign cur_entry = fwd_reg ? fwd_data_reg : mem_entry;

    nst_eval #(
        .SLOTS (SLOTS)
    ) u_eval (
        .req              (req_reg),
        .entry            (cur_entry),
        .admission_closed (admission_closed),
        .mask_in          (mask_reg),
        .count_in         (count_reg),
        .res              (eval_res),
        .wr               (eval_wr)
    );

    // request and forwarding payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg      <= s_req;
            fwd_data_reg <= eval_wr.data;
        end
        if (advance) begin
            out_reg <= eval_res;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            count_reg     <= '0;
        end else begin
            if (s_accept) begin
                req_valid_reg <= 1'b1;
                fwd_reg       <= mem_wr.en &&
                                 (req_reg.slot[IDX_W-1:0] == s_slot[IDX_W-1:0]);
            end else if (advance) begin
                req_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mask_reg      <= eval_res.pending_mask;
                count_reg     <= eval_res.pending_count;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_accepted        = out_reg.accepted;
    assign m_new_generation  = out_reg.new_generation;
    assign m_pending_mask    = out_reg.pending_mask;
    assign m_pending_count   = out_reg.pending_count;
    assign m_activate        = out_reg.activate;
    assign m_mirror_sequence = out_reg.mirror_sequence;
    assign m_mirror_tag      = out_reg.mirror_tag;
    assign m_mirror_write    = out_reg.mirror_write;

endmodule
